[hw/rtl/knn_pkg.sv]
// shared constants, codes and types of the nearest-neighbour classifier
`timescale 1ns / 1ps

package knn_pkg;

  localparam int TRAIN_DEPTH_DEF  = 128;
  localparam int K_MAX_DEF        = 16;
  localparam int FEATURE_BITS_DEF = 8;

  localparam int NUM_FEAT      = 4;
  localparam int FEAT_IN_BITS  = 8;
  localparam int SLOT_BITS     = 7;
  localparam int OP_BITS       = 2;
  localparam int CLASS_BITS    = 2;
  localparam int NEIGH_BITS    = 5;
  localparam int TCOUNT_BITS   = 8;
  localparam int CFG_DATA_BITS = 8;
  localparam int CFG_IDX_BITS  = 1;
  localparam int COUNT_BITS    = 16;

  localparam logic [NEIGH_BITS-1:0]  NEIGHBOR_RESET = 5'd1;
  localparam logic [TCOUNT_BITS-1:0] TRAIN_RESET    = 8'd100;
  localparam logic [CLASS_BITS-1:0]  CLASS_NONE     = 2'd3;
  localparam logic [COUNT_BITS-1:0]  COUNT_FULL     = 16'hFFFF;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NEIGHBOR_COUNT = 1'b0,
    CFG_TRAIN_COUNT    = 1'b1
  } cfg_idx_t;

  // status of the distance pipeline
  typedef struct packed {
    logic busy;
    logic valid;
  } dist_stat_t;

endpackage

[hw/rtl/knn_dist.sv]
// pipelined squared-distance unit, one training row per cycle
`timescale 1ns / 1ps

module knn_dist #(
  parameter int  FEATURE_BITS = knn_pkg::FEATURE_BITS_DEF,
  localparam int ROW_W        = knn_pkg::NUM_FEAT * FEATURE_BITS,
  localparam int DW           = 2 * FEATURE_BITS + 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [ROW_W-1:0]                in_row,
  input  logic [knn_pkg::CLASS_BITS-1:0]  in_cls,
  input  logic [ROW_W-1:0]                query,
  output knn_pkg::dist_stat_t             out_stat,
  output logic [DW-1:0]                   out_dist,
  output logic [knn_pkg::CLASS_BITS-1:0]  out_cls
);
  import knn_pkg::*;

  localparam int SQ_W = 2 * FEATURE_BITS;

  logic                    v1_r, v2_r, v3_r;
  logic [FEATURE_BITS-1:0] diff_r [NUM_FEAT];
  logic [FEATURE_BITS-1:0] diff_nxt [NUM_FEAT];
  logic [SQ_W-1:0]         sq_r [NUM_FEAT];
  logic [SQ_W-1:0]         sq_nxt [NUM_FEAT];
  logic [DW-1:0]           sum_r, sum_nxt;
  logic [CLASS_BITS-1:0]   cls1_r, cls2_r, cls3_r;

  always_comb begin
    logic [FEATURE_BITS-1:0] a, b;
    for (int f = 0; f < NUM_FEAT; f++) begin
      a = query[f*FEATURE_BITS +: FEATURE_BITS];
      b = in_row[f*FEATURE_BITS +: FEATURE_BITS];
      diff_nxt[f] = (a > b) ? (a - b) : (b - a);
    end
  end

  // one squarer per feature lane
  always_comb begin
    for (int f = 0; f < NUM_FEAT; f++) begin
      sq_nxt[f] = SQ_W'(diff_r[f]) * SQ_W'(diff_r[f]);
    end
  end

  assign sum_nxt = (DW'(sq_r[0]) + DW'(sq_r[1])) + (DW'(sq_r[2]) + DW'(sq_r[3]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    sq_r   <= sq_nxt;
    sum_r  <= sum_nxt;
    cls1_r <= in_cls;
    cls2_r <= cls1_r;
    cls3_r <= cls2_r;
  end

  assign out_stat.busy  = v1_r | v2_r | v3_r;
  assign out_stat.valid = v3_r;
  assign out_dist       = sum_r;
  assign out_cls        = cls3_r;

endmodule

[hw/rtl/knn_best.sv]
// sorted list of the k nearest samples, one insertion per cycle
`timescale 1ns / 1ps

module knn_best #(
  parameter int  K_MAX     = knn_pkg::K_MAX_DEF,
  parameter int  DIST_BITS = 2 * knn_pkg::FEATURE_BITS_DEF + 2,
  localparam int KW        = $clog2(K_MAX + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clear,
  input  logic [KW-1:0]                   k,
  input  logic                            in_valid,
  input  logic [DIST_BITS-1:0]            in_dist,
  input  logic [knn_pkg::CLASS_BITS-1:0]  in_cls,
  output logic [knn_pkg::CLASS_BITS-1:0]  out_cls [K_MAX],
  output logic [K_MAX-1:0]                out_vld
);
  import knn_pkg::*;

  logic [DIST_BITS-1:0]  dist_r [K_MAX];
  logic [DIST_BITS-1:0]  dist_nxt [K_MAX];
  logic [CLASS_BITS-1:0] cls_r [K_MAX];
  logic [CLASS_BITS-1:0] cls_nxt [K_MAX];
  logic [DIST_BITS-1:0]  prev_dist [K_MAX];
  logic [CLASS_BITS-1:0] prev_cls [K_MAX];
  logic [K_MAX-1:0]      vld_r, vld_nxt;
  logic [K_MAX-1:0]      ins, ins_prev, en;

  // entry above each slot, the head takes the new sample
  for (genvar g = 0; g < K_MAX; g++) begin : g_ent
    if (g == 0) begin : g_head
      assign prev_dist[g] = in_dist;
      assign prev_cls[g]  = in_cls;
    end else begin : g_rest
      assign prev_dist[g] = dist_r[g-1];
      assign prev_cls[g]  = cls_r[g-1];
    end
  end

  // empty entries count as farther; equal distance keeps the older (lower) slot
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      ins[i] = !vld_r[i] || (dist_r[i] > in_dist);
      en[i]  = in_valid && (KW'(i) < k);
    end
    ins_prev = ins << 1;
    for (int i = 0; i < K_MAX; i++) begin
      dist_nxt[i] = dist_r[i];
      cls_nxt[i]  = cls_r[i];
      if (en[i] && ins[i]) begin
        dist_nxt[i] = ins_prev[i] ? prev_dist[i] : in_dist;
        cls_nxt[i]  = ins_prev[i] ? prev_cls[i] : in_cls;
      end
    end
    // the filled part grows by one entry per insertion until k entries are filled
    vld_nxt = clear ? '0 : (vld_r | (en & ins & ((vld_r << 1) | K_MAX'(1))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    cls_r  <= cls_nxt;
  end

  assign out_cls = cls_r;
  assign out_vld = vld_r;

endmodule

[hw/rtl/knn_majority_classifier.sv]
// k-nearest-neighbour classifier: sample store, scan sequencer and vote
`timescale 1ns / 1ps
// A load, clear or no-op request is handled while busy stays low. A query
// raises busy until the result strobe. With n = min(train_count,
// TRAIN_DEPTH) and k = min(neighbor_count, K_MAX, n), the n sample rows
// are read from memory at one row per cycle, the distance pipeline drains,
// the k nearest entries are counted one per cycle, and a decide state
// settles the vote. The result is on the out_ ports for the single cycle
// that out_valid is high; the receiver cannot stall it.
// Slots read by a query must have been loaded; the store is not cleared.

module knn_majority_classifier #(
  parameter int TRAIN_DEPTH  = knn_pkg::TRAIN_DEPTH_DEF,
  parameter int K_MAX        = knn_pkg::K_MAX_DEF,
  parameter int FEATURE_BITS = knn_pkg::FEATURE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [knn_pkg::OP_BITS-1:0]        in_op,
  input  logic [knn_pkg::SLOT_BITS-1:0]      in_slot,
  input  logic [knn_pkg::FEAT_IN_BITS-1:0]   in_feature_0,
  input  logic [knn_pkg::FEAT_IN_BITS-1:0]   in_feature_1,
  input  logic [knn_pkg::FEAT_IN_BITS-1:0]   in_feature_2,
  input  logic [knn_pkg::FEAT_IN_BITS-1:0]   in_feature_3,
  input  logic [knn_pkg::CLASS_BITS-1:0]     in_class_label,
  output logic                               out_valid,
  output logic [knn_pkg::CLASS_BITS-1:0]     out_predicted_class,
  output logic                               out_is_correct,
  output logic [knn_pkg::COUNT_BITS-1:0]     out_correct_count,
  input  logic                               cfg_we,
  input  logic [knn_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [knn_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import knn_pkg::*;

  localparam int AW    = $clog2(TRAIN_DEPTH);
  localparam int CW    = $clog2(TRAIN_DEPTH + 1);
  localparam int KW    = $clog2(K_MAX + 1);
  localparam int KIW   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int ROW_W = NUM_FEAT * FEATURE_BITS;
  localparam int MW    = ROW_W + CLASS_BITS;
  localparam int DW    = 2 * FEATURE_BITS + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_VOTE,
    ST_DECIDE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [NEIGH_BITS-1:0]   neigh_r, neigh_nxt;
  logic [TCOUNT_BITS-1:0]  tcount_r, tcount_nxt;
  logic [COUNT_BITS-1:0]   match_r, match_nxt;
  logic [CW-1:0]           scan_len_r, scan_len_nxt;
  logic [CW-1:0]           issue_r, issue_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic [KW-1:0]           vote_idx_r, vote_idx_nxt;
  logic [KW-1:0]           votes_r [3];
  logic [KW-1:0]           votes_nxt [3];
  logic [ROW_W-1:0]        query_r, query_nxt;
  logic [CLASS_BITS-1:0]   label_r, label_nxt;
  logic                    rd_valid_r, rd_en;
  logic                    out_valid_r, out_valid_nxt;
  logic [CLASS_BITS-1:0]   out_pred_r, out_pred_nxt;
  logic                    out_ok_r, out_ok_nxt;

  logic                    accept;
  logic                    load_we;
  logic                    best_clear;
  logic [ROW_W-1:0]        feat_in;
  logic [MW-1:0]           mem [TRAIN_DEPTH];
  logic [MW-1:0]           rd_data_r;

  dist_stat_t              dist_stat;
  logic [DW-1:0]           dist_val;
  logic [CLASS_BITS-1:0]   dist_cls;
  logic [CLASS_BITS-1:0]   best_cls [K_MAX];
  logic [K_MAX-1:0]        best_vld;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign feat_in = {FEATURE_BITS'(in_feature_3), FEATURE_BITS'(in_feature_2),
                    FEATURE_BITS'(in_feature_1), FEATURE_BITS'(in_feature_0)};
  assign load_we = accept && (op_t'(in_op) == OP_LOAD) && (int'(in_slot) < TRAIN_DEPTH);
  assign best_clear = accept && (op_t'(in_op) == OP_QUERY);
  assign rd_en   = (state_r == ST_SCAN) && (issue_r != scan_len_r);

  // sample store
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[AW'(in_slot)] <= {in_class_label, feat_in};
    end
    if (rd_en) begin
      rd_data_r <= mem[issue_r[AW-1:0]];
    end
  end

  knn_dist #(
    .FEATURE_BITS (FEATURE_BITS)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_valid_r),
    .in_row   (rd_data_r[ROW_W-1:0]),
    .in_cls   (rd_data_r[ROW_W +: CLASS_BITS]),
    .query    (query_r),
    .out_stat (dist_stat),
    .out_dist (dist_val),
    .out_cls  (dist_cls)
  );

  knn_best #(
    .K_MAX     (K_MAX),
    .DIST_BITS (DW)
  ) u_best (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (best_clear),
    .k        (k_r),
    .in_valid (dist_stat.valid),
    .in_dist  (dist_val),
    .in_cls   (dist_cls),
    .out_cls  (best_cls),
    .out_vld  (best_vld)
  );

  always_comb begin
    int                    n_i;
    int                    k_i;
    logic [CLASS_BITS-1:0] vc;
    logic [CLASS_BITS-1:0] pred;

    state_nxt     = state_r;
    neigh_nxt     = neigh_r;
    tcount_nxt    = tcount_r;
    match_nxt     = match_r;
    scan_len_nxt  = scan_len_r;
    issue_nxt     = issue_r;
    k_nxt         = k_r;
    vote_idx_nxt  = vote_idx_r;
    votes_nxt     = votes_r;
    query_nxt     = query_r;
    label_nxt     = label_r;
    out_valid_nxt = 1'b0;
    out_pred_nxt  = out_pred_r;
    out_ok_nxt    = out_ok_r;
    pred          = CLASS_NONE;

    n_i = (int'(tcount_r) > TRAIN_DEPTH) ? TRAIN_DEPTH : int'(tcount_r);
    k_i = (int'(neigh_r) > K_MAX) ? K_MAX : int'(neigh_r);
    if (k_i > n_i) begin
      k_i = n_i;
    end
    vc = best_cls[vote_idx_r[KIW-1:0]];

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NEIGHBOR_COUNT: neigh_nxt = cfg_wdata[NEIGH_BITS-1:0];
        CFG_TRAIN_COUNT:    tcount_nxt = cfg_wdata[TCOUNT_BITS-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_op))
            OP_QUERY: begin
              scan_len_nxt = CW'(n_i);
              k_nxt        = KW'(k_i);
              issue_nxt    = '0;
              vote_idx_nxt = '0;
              votes_nxt    = '{default: '0};
              query_nxt    = feat_in;
              label_nxt    = in_class_label;
              state_nxt    = ST_SCAN;
            end
            OP_CLEAR: match_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue_r == scan_len_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          issue_nxt = issue_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        // last insertion has landed once the read stage and pipeline are empty
        if (!rd_valid_r && !dist_stat.busy) begin
          state_nxt = ST_VOTE;
        end
      end
      ST_VOTE: begin
        if (vote_idx_r == k_r) begin
          state_nxt = ST_DECIDE;
        end else begin
          vote_idx_nxt = vote_idx_r + KW'(1);
          if (best_vld[vote_idx_r[KIW-1:0]] && (vc != CLASS_NONE)) begin
            votes_nxt[vc] = votes_r[vc] + KW'(1);
          end
        end
      end
      ST_DECIDE: begin
        if ((votes_r[0] > votes_r[1]) && (votes_r[0] > votes_r[2])) begin
          pred = 2'd0;
        end else if ((votes_r[1] > votes_r[0]) && (votes_r[1] > votes_r[2])) begin
          pred = 2'd1;
        end else if ((votes_r[2] > votes_r[0]) && (votes_r[2] > votes_r[1])) begin
          pred = 2'd2;
        end
        out_pred_nxt  = pred;
        out_ok_nxt    = (pred != CLASS_NONE) && (pred == label_r);
        if (out_ok_nxt && (match_r != COUNT_FULL)) begin
          match_nxt = match_r + COUNT_BITS'(1);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      neigh_r     <= NEIGHBOR_RESET;
      tcount_r    <= TRAIN_RESET;
      match_r     <= '0;
      scan_len_r  <= '0;
      issue_r     <= '0;
      k_r         <= '0;
      vote_idx_r  <= '0;
      votes_r     <= '{default: '0};
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_pred_r  <= CLASS_NONE;
      out_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      neigh_r     <= neigh_nxt;
      tcount_r    <= tcount_nxt;
      match_r     <= match_nxt;
      scan_len_r  <= scan_len_nxt;
      issue_r     <= issue_nxt;
      k_r         <= k_nxt;
      vote_idx_r  <= vote_idx_nxt;
      votes_r     <= votes_nxt;
      rd_valid_r  <= rd_en;
      out_valid_r <= out_valid_nxt;
      out_pred_r  <= out_pred_nxt;
      out_ok_r    <= out_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r <= query_nxt;
    label_r <= label_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_pred_r;
  assign out_is_correct      = out_ok_r;
  assign out_correct_count   = match_r;

endmodule

[hw/rtl/knn_chk.sv]
// port-level checks of the classifier, bound to the top level
`timescale 1ns / 1ps

module knn_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [knn_pkg::OP_BITS-1:0]     in_op,
  input logic                            out_valid,
  input logic [knn_pkg::CLASS_BITS-1:0]  out_predicted_class,
  input logic                            out_is_correct
);
  import knn_pkg::*;

  // a result only follows a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding query");

  // the block is free again while the result is shown
  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy still high with the result strobe");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_QUERY)) |=> busy)
    else $error("query request did not raise busy");

  a_other_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op != OP_QUERY)) |=> (!busy && !out_valid))
    else $error("non-query request occupied the block or gave a result");

  a_correct_has_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_correct) |-> (out_predicted_class != CLASS_NONE))
    else $error("match flagged without a majority class");

endmodule

bind knn_majority_classifier knn_chk u_knn_chk (.*);
